@@ rtl/mbp_pkg.sv @@
// shared types, constants and helpers of the msb-first bit packer
package mbp_pkg;

    localparam int AccBits  = 32;
    localparam int FreeW    = 6;
    localparam int ByteCntW = 29;
    localparam int LeftW    = 3;
    localparam int QDepth   = 4;
    localparam int QPtrW    = 2;
    localparam int QCntW    = 3;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_FLUSH = 2'd1;
    localparam logic [1:0] REQ_POS   = 2'd2;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_POS  = 1'b1;

    // one unit of output work: a word to send as bytes, or a position report
    typedef struct packed {
        logic                     kind;
        logic [AccBits-1:0]       data;
        logic [LeftW-1:0]         count;
    } t_job;

    // low n bits set, n in 0..63; 32 and above give all ones
    function automatic logic [AccBits-1:0] low_ones(input logic [FreeW-1:0] n);
        logic [AccBits-1:0] m;
        if (n >= FreeW'(AccBits)) begin
            m = '1;
        end else begin
            m = (AccBits'(1) << n) - AccBits'(1);
        end
        return m;
    endfunction

endpackage

@@ rtl/msb_first_bit_packer_core.sv @@
// top level of the msb-first bit packer: front, job queue and serializer
// path: a request's job is written into the job queue at its accepting edge; the back then
// loads it from the queue into its output register, from which the first beat is presented
// throughput: a request is taken every cycle while the four-entry job queue has room;
// sustained rate is set by the byte-wide output: an overflowing put costs four beats
// reset: synchronous active-low i_rst_n empties the queue and serializer and resets the front
module msb_first_bit_packer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // nbits[5:0], value[37:6], zero[39:38]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_byte[7:0], bit_position[39:8]
    output logic [0:0]  m_axis_tuser,   // result_kind[0]
    output logic        m_axis_tlast    // last beat caused by a request
);
    import mbp_pkg::*;

    // accumulator and byte count reset to zero, free bits to 32; no clearing pass is needed

    // front to queue
    logic  fr_push;
    t_job  fr_job;
    logic  q_ready;
    // queue to back
    logic  q_valid;
    logic  bk_pop;
    t_job  q_job;
    // back outputs
    logic        bk_kind;
    logic [7:0]  bk_byte;
    logic [31:0] bk_pos;

    // front: updates the accumulator state once per accepted request
    mbp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_req     (s_axis_tuser),
        .i_nbits   (s_axis_tdata[5:0]),
        .i_value   (s_axis_tdata[37:6]),
        .i_q_ready (q_ready),
        .o_push    (fr_push),
        .o_job     (fr_job)
    );

    // queue: lets a stalled output side keep the front running up to four jobs ahead
    mbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_job   (fr_job),
        .o_ready (q_ready),
        .i_pop   (bk_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // back: registered output, shifts out bytes high first
    mbp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (q_job),
        .o_pop     (bk_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_kind    (bk_kind),
        .o_byte    (bk_byte),
        .o_pos     (bk_pos),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {bk_pos, bk_byte};
    assign m_axis_tuser = bk_kind;

endmodule

@@ rtl/mbp_front.sv @@
// request decode, accumulator update and job generation
module mbp_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_req,
    input  logic [5:0]                  i_nbits,
    input  logic [31:0]                 i_value,
    input  logic                        i_q_ready,
    output logic                        o_push,
    output mbp_pkg::t_job               o_job
);
    import mbp_pkg::*;

    logic [AccBits-1:0]  r_acc, n_acc;
    logic [FreeW-1:0]    r_free, n_free;
    logic [ByteCntW-1:0] r_bytes, n_bytes;
    logic [FreeW-1:0]    n_sat;
    logic [FreeW-1:0]    rest;
    logic [LeftW-1:0]    fl_cnt;
    logic                job_vld;
    logic                accept;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign n_sat   = (i_nbits > FreeW'(AccBits)) ? FreeW'(AccBits) : i_nbits;
    assign rest    = n_sat - r_free;
    assign fl_cnt  = LeftW'(4) - LeftW'(r_free[FreeW-1:3]);

    always_comb begin
        n_acc   = r_acc;
        n_free  = r_free;
        n_bytes = r_bytes;
        job_vld = 1'b0;
        o_job   = '0;
        unique case (i_req)
            REQ_PUT: begin
                if (n_sat != '0) begin
                    if (n_sat <= r_free) begin
                        n_acc  = r_acc | ((i_value & low_ones(n_sat)) << (r_free - n_sat));
                        n_free = r_free - n_sat;
                    end else begin
                        // top up the word with the leading code bits, send it
                        job_vld     = 1'b1;
                        o_job.kind  = KIND_BYTE;
                        o_job.data  = r_acc | ((i_value >> rest) & low_ones(r_free));
                        o_job.count = LeftW'(4);
                        n_acc       = i_value << (FreeW'(AccBits) - rest);
                        n_free      = FreeW'(AccBits) - rest;
                        n_bytes     = r_bytes + ByteCntW'(4);
                    end
                end
            end
            REQ_FLUSH: begin
                job_vld     = (fl_cnt != '0);
                o_job.kind  = KIND_BYTE;
                o_job.data  = r_acc;
                o_job.count = fl_cnt;
                n_acc       = '0;
                n_free      = FreeW'(AccBits);
                n_bytes     = '0;
            end
            REQ_POS: begin
                job_vld     = 1'b1;
                o_job.kind  = KIND_POS;
                o_job.data  = {r_bytes, 3'b000} + AccBits'(FreeW'(AccBits) - r_free);
                o_job.count = LeftW'(1);
            end
            default: begin
                job_vld = 1'b0;
            end
        endcase
    end

    assign o_push = accept && job_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_free  <= FreeW'(AccBits);
            r_bytes <= '0;
        end else if (accept) begin
            r_acc   <= n_acc;
            r_free  <= n_free;
            r_bytes <= n_bytes;
        end
    end

`ifndef SYNTHESIS
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FreeW'(AccBits))
        else $error("free bit count out of range");
`endif

endmodule

@@ rtl/mbp_queue.sv @@
// short job queue between front and back
module mbp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mbp_pkg::t_job i_job,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output mbp_pkg::t_job o_job
);
    import mbp_pkg::*;

    t_job             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr, r_rd;
    logic [QCntW-1:0] r_count;

    assign o_ready = (r_count != QCntW'(QDepth));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPtrW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCntW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCntW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != QCntW'(QDepth)))
        else $error("push into full queue");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");
`endif

endmodule

@@ rtl/mbp_back.sv @@
// job serializer: one byte or one position report per output beat
module mbp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  mbp_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_kind,
    output logic [7:0]    o_byte,
    output logic [31:0]   o_pos,
    output logic          o_last
);
    import mbp_pkg::*;

    logic               r_valid;
    logic               r_kind;
    logic [AccBits-1:0] r_word;
    logic [LeftW-1:0]   r_left;
    logic               beat;

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_last  = (r_left == LeftW'(1));
    assign o_byte  = (r_kind == KIND_BYTE) ? r_word[AccBits-1 -: 8] : 8'd0;
    assign o_pos   = (r_kind == KIND_POS) ? r_word : '0;
    assign beat    = r_valid && i_ready;
    assign o_pop   = i_q_valid && (!r_valid || (beat && o_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_left  <= i_job.count;
        end else if (beat) begin
            r_valid <= !o_last;
            r_left  <= r_left - LeftW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_job.kind;
            r_word <= i_job.data;
        end else if (beat) begin
            r_word <= r_word << 8;
        end
    end

`ifndef SYNTHESIS
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_left != '0 && r_left <= LeftW'(4)))
        else $error("remaining beat count out of range");
    a_hold_mid_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat && !o_last) |=> r_valid)
        else $error("job dropped before its last beat");
`endif

endmodule

@@ sim/msb_packer_monitor.sv @@
// monitor for the msb-first bit packer: predicts result beats and compares them
`timescale 1ns / 100ps

module msb_packer_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel, watched only
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [39:0] i_req_data,    // nbits[5:0], value[37:6], zero[39:38]
    input  logic [1:0]  i_req_user,    // req_type[1:0]
    // result channel, watched only
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [39:0] i_res_data,    // out_byte[7:0], bit_position[39:8]
    input  logic [0:0]  i_res_user,    // result_kind[0]
    input  logic        i_res_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_beats_checked
);
    import mbp_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic [31:0] bit_pos;
        logic        last;
    } t_stream_beat;

    t_stream_beat stream_beats_due[$];

    // shadow of the packer state
    logic [AccBits-1:0]  word_acc;
    logic [FreeW-1:0]    room_bits;
    logic [ByteCntW-1:0] sent_bytes;

    int fail_count    = 0;
    int beats_checked = 0;
    int pending_cnt   = 0;

    assign o_fail_count    = fail_count;
    assign o_pending       = pending_cnt;
    assign o_beats_checked = beats_checked;

    function automatic logic [31:0] code_mask(input int unsigned n);
        if (n >= 32) begin
            return 32'hFFFF_FFFF;
        end
        return (32'd1 << n) - 32'd1;
    endfunction

    // top bytes of the word, high byte first; tlast on the final one
    task automatic queue_word_bytes(input int unsigned count);
        t_stream_beat b;
        for (int unsigned i = 0; i < count; i++) begin
            b.kind     = KIND_BYTE;
            b.out_byte = 8'((word_acc >> (24 - 8 * i)) & 32'hFF);
            b.bit_pos  = '0;
            b.last     = (i == count - 1);
            stream_beats_due.push_back(b);
            sent_bytes = sent_bytes + ByteCntW'(1);
        end
    endtask

    task automatic pack_request(input logic [1:0] req, input logic [5:0] nbits,
                                input logic [31:0] code);
        int unsigned  n;
        int unsigned  spill;
        int unsigned  count;
        t_stream_beat b;
        n = nbits;
        case (req)
            REQ_PUT: begin
                if (n != 0) begin
                    if (n > 32) begin
                        n = 32;
                    end
                    if (n <= room_bits) begin
                        word_acc  = word_acc | ((code & code_mask(n)) << (room_bits - n));
                        room_bits = FreeW'(room_bits - n);
                    end else begin
                        // top up the word with the leading bits, ship it, keep the rest
                        spill = n - room_bits;
                        if (room_bits != 0) begin
                            word_acc = word_acc | ((code >> spill) & code_mask(room_bits));
                        end
                        queue_word_bytes(4);
                        if (spill >= 32) begin
                            word_acc = code;
                        end else begin
                            word_acc = (code & code_mask(spill)) << (32 - spill);
                        end
                        room_bits = FreeW'(32 - spill);
                    end
                end
            end
            REQ_FLUSH: begin
                // only bytes holding a written bit go out
                count = 4 - room_bits / 8;
                queue_word_bytes(count);
                word_acc   = '0;
                room_bits  = FreeW'(AccBits);
                sent_bytes = '0;
            end
            REQ_POS: begin
                b.kind     = KIND_POS;
                b.out_byte = '0;
                b.bit_pos  = {sent_bytes, 3'b000} + (32 - room_bits);
                b.last     = 1'b1;
                stream_beats_due.push_back(b);
            end
            default: begin
            end
        endcase
    endtask

    task automatic note_failure(input bit unexpected, input t_stream_beat want,
                                input t_stream_beat got);
        fail_count++;
        if (fail_count <= 10) begin
            if (unexpected) begin
                $display("%0t: beat with nothing expected: kind %0d byte %02h pos %0d last %0d",
                         $realtime, got.kind, got.out_byte, got.bit_pos, got.last);
            end else begin
                $display("%0t: beat mismatch: expected kind %0d byte %02h pos %0d last %0d",
                         $realtime, want.kind, want.out_byte, want.bit_pos, want.last);
                $display("%0t:                  got kind %0d byte %02h pos %0d last %0d",
                         $realtime, got.kind, got.out_byte, got.bit_pos, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_stream_beat got;
        t_stream_beat want;
        if (!i_rst_n) begin
            word_acc   = '0;
            room_bits  = FreeW'(AccBits);
            sent_bytes = '0;
            stream_beats_due.delete();
        end else begin
            // results first, so a beat cannot be matched against this edge's request
            if (i_res_valid && i_res_ready) begin
                got.kind     = i_res_user[0];
                got.out_byte = i_res_data[7:0];
                got.bit_pos  = i_res_data[39:8];
                got.last     = i_res_last;
                beats_checked++;
                if (stream_beats_due.size() == 0) begin
                    note_failure(1'b1, got, got);
                end else begin
                    want = stream_beats_due.pop_front();
                    if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                        got.bit_pos !== want.bit_pos || got.last !== want.last) begin
                        note_failure(1'b0, want, got);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                pack_request(i_req_user, i_req_data[5:0], i_req_data[37:6]);
            end
        end
        pending_cnt = stream_beats_due.size();
    end

endmodule

@@ sim/tb_msb_first_bit_packer_core.sv @@
// testbench top for the msb-first bit packer: stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module tb_msb_first_bit_packer_core;
    import mbp_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_REQS  = 300;
    localparam int DRAIN_CYCLES = 8;
    // timeout set far above the length of the slowest run
    localparam int TIMEOUT_NS   = 400_000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;    // nbits[5:0], value[37:6], zero[39:38]
    logic [1:0]  s_axis_tuser  = '0;    // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // out_byte[7:0], bit_position[39:8]
    logic [0:0]  m_axis_tuser;          // result_kind[0]
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int beats_checked;

    int burst_left = 0;
    int rx_cycle   = 0;
    int n_put      = 0;
    int n_flush    = 0;
    int n_pos      = 0;
    int n_ignored  = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    msb_first_bit_packer_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    msb_packer_monitor u_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (s_axis_tvalid),
        .i_req_ready     (s_axis_tready),
        .i_req_data      (s_axis_tdata),
        .i_req_user      (s_axis_tuser),
        .i_res_valid     (m_axis_tvalid),
        .i_res_ready     (m_axis_tready),
        .i_res_data      (m_axis_tdata),
        .i_res_user      (m_axis_tuser),
        .i_res_last      (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_beats_checked (beats_checked)
    );

    // receiver: cycles through always-ready, coin-flip, one-in-four and mostly-ready phases
    always @(negedge i_clk) begin
        rx_cycle++;
        case ((rx_cycle / 150) % 4)
            0: m_axis_tready = 1'b1;
            1: m_axis_tready = 1'($urandom_range(0, 1));
            2: m_axis_tready = ((rx_cycle % 4) == 0);
            default: m_axis_tready = ($urandom_range(0, 3) != 0);
        endcase
    end

    // one request beat; the sender runs in bursts with idle gaps between them
    task automatic send_req(input logic [1:0] req, input logic [5:0] nbits,
                            input logic [31:0] code);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
            end
            // now and then a long stretch with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {2'b00, code, nbits};
        s_axis_tuser  = req;
        do @(posedge i_clk); while (!s_axis_tready);
        case (req)
            REQ_PUT:   if (nbits != 0) n_put++; else n_ignored++;
            REQ_FLUSH: n_flush++;
            REQ_POS:   n_pos++;
            default:   n_ignored++;
        endcase
    endtask

    // random request; reports whether it is one the packer acts on
    task automatic send_random_req(output bit acted);
        int          pick;
        int          len_sel;
        logic [5:0]  nbits;
        logic [31:0] code;
        pick    = $urandom_range(0, 99);
        len_sel = $urandom_range(0, 19);
        code    = $urandom;
        case ($urandom_range(0, 9))
            0: code = '1;
            1: code = '0;
            default: begin
            end
        endcase
        // short codes dominate, full-width and oversize ones show up regularly
        if (len_sel == 0) begin
            nbits = 6'd0;
        end else if (len_sel == 1) begin
            nbits = 6'($urandom_range(33, 63));
        end else if (len_sel < 4) begin
            nbits = 6'd32;
        end else if (len_sel < 10) begin
            nbits = 6'($urandom_range(1, 8));
        end else begin
            nbits = 6'($urandom_range(1, 32));
        end
        if (pick < 75) begin
            send_req(REQ_PUT, nbits, code);
            acted = (nbits != 0);
        end else if (pick < 83) begin
            send_req(REQ_FLUSH, nbits, code);
            acted = 1'b1;
        end else if (pick < 96) begin
            send_req(REQ_POS, nbits, code);
            acted = 1'b1;
        end else begin
            send_req(REQ_UNUSED, nbits, code);
            acted = 1'b0;
        end
    endtask

    initial begin
        int taken;
        bit acted;
        taken = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part
        send_req(REQ_POS,    6'd0,  32'h0000_0000);  // position right after reset
        send_req(REQ_FLUSH,  6'd0,  32'h0000_0000);  // flush with nothing written
        send_req(REQ_PUT,    6'd0,  32'hFFFF_FFFF);  // zero-length put is dropped
        send_req(REQ_PUT,    6'd32, 32'hFFFF_FFFF);  // exact fill, word stays put
        send_req(REQ_POS,    6'd63, 32'hFFFF_FFFF);
        send_req(REQ_PUT,    6'd1,  32'h0000_0001);  // overflow from a full word
        send_req(REQ_PUT,    6'd63, 32'hA5A5_5A5A);  // oversize length saturates to 32
        send_req(REQ_PUT,    6'd32, 32'h0000_0000);
        send_req(REQ_UNUSED, 6'd63, 32'hFFFF_FFFF);  // unused request type
        send_req(REQ_PUT,    6'd7,  32'hFFFF_FF95);  // high garbage above the code
        send_req(REQ_POS,    6'd0,  32'h0000_0000);
        send_req(REQ_FLUSH,  6'd0,  32'h0000_0000);  // partial word
        send_req(REQ_PUT,    6'd8,  32'h0000_00C3);
        send_req(REQ_FLUSH,  6'd63, 32'hFFFF_FFFF);  // exactly one byte
        send_req(REQ_PUT,    6'd32, 32'h1234_5678);
        send_req(REQ_FLUSH,  6'd0,  32'h0000_0000);  // full word
        send_req(REQ_POS,    6'd0,  32'h0000_0000);  // count cleared by the flush
        send_req(REQ_PUT,    6'd1,  32'h0000_0001);
        send_req(REQ_PUT,    6'd32, 32'h8000_0001);  // overflow with one spill bit
        send_req(REQ_PUT,    6'd31, 32'h7FFF_FFFF);  // fills the word to the brim
        send_req(REQ_PUT,    6'd32, 32'hDEAD_BEEF);  // overflow from a full word, 32 spill
        send_req(REQ_POS,    6'd0,  32'h0000_0000);
        send_req(REQ_PUT,    6'd9,  32'h0000_01FF);
        send_req(REQ_FLUSH,  6'd0,  32'h0000_0000);

        // random part
        while (taken < RANDOM_REQS) begin
            send_random_req(acted);
            if (acted) begin
                taken++;
            end
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        // catch stray beats after the expected ones have all arrived
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d puts, %0d flushes, %0d position reads, %0d ignored requests",
                 n_put, n_flush, n_pos, n_ignored);
        $display("%0d result beats checked under random stalls, %0d failures",
                 beats_checked, fail_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timed out with %0d beats still expected", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule
